// ===== hw/rtl/grid_ray_dda_traversal_core_assert.svh =====
// assertion macros for the rtl files, included by grdda_ctrl.sv
`ifndef GRID_RAY_DDA_TRAVERSAL_CORE_ASSERT_SVH
`define GRID_RAY_DDA_TRAVERSAL_CORE_ASSERT_SVH

// same-cycle implication, sampled on clk, off during reset
`define GRDDA_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication, sampled on clk, off during reset
`define GRDDA_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== hw/rtl/grdda_pkg.sv =====
package grdda_pkg;

  localparam int unsigned CELL_W  = 6;
  localparam int unsigned POS_W   = 22;
  localparam int unsigned DELTA_W = 24;
  localparam int unsigned DIST_W  = 32;
  localparam int unsigned FRAC_W  = 16;
  localparam int unsigned OFF_W   = 23;
  localparam int unsigned PROD_W  = OFF_W + DELTA_W;

  localparam logic [DELTA_W-1:0] DELTA_INF = '1;

  localparam logic ACT_WRITE = 1'b0;
  localparam logic ACT_CAST  = 1'b1;

  localparam logic STAT_WALL = 1'b0;
  localparam logic STAT_MISS = 1'b1;

  localparam logic AXIS_X = 1'b0;
  localparam logic AXIS_Y = 1'b1;

  typedef struct packed {
    logic               action;
    logic [CELL_W-1:0]  cell_x;
    logic [CELL_W-1:0]  cell_y;
    logic               wall;
    logic [POS_W-1:0]   pos_x;
    logic [POS_W-1:0]   pos_y;
    logic               dir_x_negative;
    logic               dir_y_negative;
    logic [DELTA_W-1:0] delta_x;
    logic [DELTA_W-1:0] delta_y;
  } grdda_in_t;

  typedef struct packed {
    logic              status;
    logic              hit_axis;
    logic [CELL_W-1:0] hit_cell_x;
    logic [CELL_W-1:0] hit_cell_y;
    logic [DIST_W-1:0] side_dist_x;
    logic [DIST_W-1:0] side_dist_y;
  } grdda_out_t;

  // controller to datapath
  typedef struct packed {
    logic clear;
    logic write;
    logic load;
    logic offset;
    logic mul_x;
    logic mul_y;
    logic set_y;
    logic step;
    logic check;
    logic finish;
  } grdda_cmd_t;

  // datapath to controller
  typedef struct packed {
    logic clear_last;
    logic start_in_map;
    logic step_out;
    logic wall;
    logic limit;
  } grdda_sts_t;

endpackage

// ===== hw/rtl/grdda_if.sv =====
interface grdda_in_if;
  logic                  valid;
  logic                  ready;
  grdda_pkg::grdda_in_t  data;

  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

interface grdda_out_if;
  logic                  valid;
  logic                  ready;
  grdda_pkg::grdda_out_t data;

  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

// ===== hw/rtl/grdda_dp.sv =====
module grdda_dp #(
  parameter int unsigned MAP_SIZE  = 64,
  parameter int unsigned MAX_STEPS = 128
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  grdda_pkg::grdda_cmd_t cmd,
  input  grdda_pkg::grdda_in_t  in_data,
  output grdda_pkg::grdda_sts_t sts,
  output grdda_pkg::grdda_out_t out_data
);

  localparam int unsigned CW    = $clog2(MAP_SIZE);
  localparam int unsigned XW    = (CW > grdda_pkg::CELL_W) ? CW + 1 : grdda_pkg::CELL_W + 1;
  localparam int unsigned DEPTH = MAP_SIZE * MAP_SIZE;
  localparam int unsigned AW    = $clog2(DEPTH);
  localparam int unsigned NW    = $clog2(MAX_STEPS + 1);
  localparam int unsigned DW    = grdda_pkg::DIST_W;

  function automatic logic [grdda_pkg::OFF_W-1:0] side_off(
    input logic [grdda_pkg::CELL_W-1:0] c,
    input logic [grdda_pkg::POS_W-1:0]  p,
    input logic                         neg
  );
    logic [grdda_pkg::OFF_W-1:0] e_lo;
    logic [grdda_pkg::OFF_W-1:0] e_hi;
    logic [grdda_pkg::OFF_W-1:0] pz;
    e_lo = {1'b0, c, {grdda_pkg::FRAC_W{1'b0}}};
    e_hi = {({1'b0, c} + 7'd1), {grdda_pkg::FRAC_W{1'b0}}};
    pz   = {1'b0, p};
    if (neg) begin
      return (pz > e_lo) ? pz - e_lo : '0;
    end else begin
      return (e_hi > pz) ? e_hi - pz : '0;
    end
  endfunction

  // wall map
  logic map_mem [DEPTH];
  logic rdata_r;

  logic [AW-1:0] clr_cnt_r;

  logic [XW-1:0] x_r, y_r;
  logic [grdda_pkg::POS_W-1:0]   px_r, py_r;
  logic                          nx_r, ny_r;
  logic [grdda_pkg::DELTA_W-1:0] dx_r, dy_r;
  logic [grdda_pkg::OFF_W-1:0]   offx_r, offy_r;
  logic [grdda_pkg::PROD_W-1:0]  prod_r;
  logic [DW-1:0]                 sx_r, sy_r;
  logic [NW-1:0]                 n_r;
  logic                          stat_r, axis_r;
  grdda_pkg::grdda_out_t         out_r;

  logic          take_x;
  logic [DW:0]   sum_x, sum_y;
  logic [DW-1:0] sx_step, sy_step;
  logic [DW-1:0] side_val;
  logic          x_edge, y_edge;
  logic [XW-1:0] nxt_x, nxt_y;
  logic [AW-1:0] rd_addr, wr_addr;
  logic          wr_in_range;

  always_comb begin
    take_x  = sx_r < sy_r;
    sum_x   = {1'b0, sx_r} + (DW + 1)'(dx_r);
    sum_y   = {1'b0, sy_r} + (DW + 1)'(dy_r);
    sx_step = (dx_r == grdda_pkg::DELTA_INF) ? '1 : (sum_x[DW] ? '1 : sum_x[DW-1:0]);
    sy_step = (dy_r == grdda_pkg::DELTA_INF) ? '1 : (sum_y[DW] ? '1 : sum_y[DW-1:0]);
    side_val = DW'(prod_r >> grdda_pkg::FRAC_W);
    x_edge  = nx_r ? (x_r == '0) : (x_r == XW'(MAP_SIZE - 1));
    y_edge  = ny_r ? (y_r == '0) : (y_r == XW'(MAP_SIZE - 1));
    nxt_x   = x_r;
    nxt_y   = y_r;
    if (take_x) begin
      nxt_x = nx_r ? x_r - XW'(1) : x_r + XW'(1);
    end else begin
      nxt_y = ny_r ? y_r - XW'(1) : y_r + XW'(1);
    end
    rd_addr = AW'(AW'(nxt_x) * AW'(MAP_SIZE)) + AW'(nxt_y);
    wr_addr = AW'(AW'(in_data.cell_x) * AW'(MAP_SIZE)) + AW'(in_data.cell_y);
    wr_in_range = (XW'(in_data.cell_x) < XW'(MAP_SIZE)) &&
                  (XW'(in_data.cell_y) < XW'(MAP_SIZE));
  end

  always_ff @(posedge clk) begin
    if (cmd.clear) begin
      map_mem[clr_cnt_r] <= 1'b0;
    end else if (cmd.write && wr_in_range) begin
      map_mem[wr_addr] <= in_data.wall;
    end
    if (cmd.step) begin
      rdata_r <= map_mem[rd_addr];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      clr_cnt_r <= '0;
    end else if (cmd.clear) begin
      clr_cnt_r <= clr_cnt_r + AW'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      x_r    <= XW'(in_data.cell_x);
      y_r    <= XW'(in_data.cell_y);
      px_r   <= in_data.pos_x;
      py_r   <= in_data.pos_y;
      nx_r   <= in_data.dir_x_negative;
      ny_r   <= in_data.dir_y_negative;
      dx_r   <= in_data.delta_x;
      dy_r   <= in_data.delta_y;
      n_r    <= '0;
      stat_r <= grdda_pkg::STAT_MISS;
      axis_r <= grdda_pkg::AXIS_X;
    end
    if (cmd.offset) begin
      offx_r <= side_off(x_r[grdda_pkg::CELL_W-1:0], px_r, nx_r);
      offy_r <= side_off(y_r[grdda_pkg::CELL_W-1:0], py_r, ny_r);
    end
    if (cmd.mul_x) begin
      prod_r <= grdda_pkg::PROD_W'(offx_r) * grdda_pkg::PROD_W'(dx_r);
    end
    if (cmd.mul_y) begin
      sx_r   <= (dx_r == grdda_pkg::DELTA_INF) ? '1 : side_val;
      prod_r <= grdda_pkg::PROD_W'(offy_r) * grdda_pkg::PROD_W'(dy_r);
    end
    if (cmd.set_y) begin
      sy_r <= (dy_r == grdda_pkg::DELTA_INF) ? '1 : side_val;
    end
    if (cmd.step) begin
      if (take_x) begin
        sx_r   <= sx_step;
        axis_r <= grdda_pkg::AXIS_X;
      end else begin
        sy_r   <= sy_step;
        axis_r <= grdda_pkg::AXIS_Y;
      end
      if (!(take_x ? x_edge : y_edge)) begin
        x_r <= nxt_x;
        y_r <= nxt_y;
        n_r <= n_r + NW'(1);
      end
    end
    if (cmd.check && rdata_r) begin
      stat_r <= grdda_pkg::STAT_WALL;
    end
    if (cmd.finish) begin
      out_r.status      <= stat_r;
      out_r.hit_axis    <= axis_r;
      out_r.hit_cell_x  <= x_r[grdda_pkg::CELL_W-1:0];
      out_r.hit_cell_y  <= y_r[grdda_pkg::CELL_W-1:0];
      out_r.side_dist_x <= sx_r;
      out_r.side_dist_y <= sy_r;
    end
  end

  always_comb begin
    sts.clear_last   = clr_cnt_r == AW'(DEPTH - 1);
    sts.start_in_map = (x_r < XW'(MAP_SIZE)) && (y_r < XW'(MAP_SIZE));
    sts.step_out     = take_x ? x_edge : y_edge;
    sts.wall         = rdata_r;
    sts.limit        = n_r == NW'(MAX_STEPS);
  end

  assign out_data = out_r;

endmodule

// ===== hw/rtl/grdda_ctrl.sv =====
`include "grid_ray_dda_traversal_core_assert.svh"

module grdda_ctrl (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  in_valid,
  input  logic                  in_action,
  output logic                  in_ready,
  input  logic                  out_ready,
  output logic                  out_valid,
  output grdda_pkg::grdda_cmd_t cmd,
  input  grdda_pkg::grdda_sts_t sts
);

  typedef enum logic [3:0] {
    S_CLEAR,
    S_IDLE,
    S_OFS,
    S_MULX,
    S_MULY,
    S_SETY,
    S_STEP,
    S_CHECK,
    S_DONE
  } state_t;

  state_t state_r;
  logic   out_valid_r;
  logic   accept;

  assign in_ready  = state_r == S_IDLE;
  assign accept    = in_valid && in_ready;
  assign out_valid = out_valid_r;

  always_comb begin
    cmd        = '0;
    cmd.clear  = state_r == S_CLEAR;
    cmd.write  = accept && (in_action == grdda_pkg::ACT_WRITE);
    cmd.load   = accept && (in_action == grdda_pkg::ACT_CAST);
    cmd.offset = state_r == S_OFS;
    cmd.mul_x  = state_r == S_MULX;
    cmd.mul_y  = state_r == S_MULY;
    cmd.set_y  = state_r == S_SETY;
    cmd.step   = state_r == S_STEP;
    cmd.check  = state_r == S_CHECK;
    cmd.finish = (state_r == S_DONE) && (!out_valid_r || out_ready);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_CLEAR;
      out_valid_r <= 1'b0;
    end else begin
      if (cmd.finish) begin
        out_valid_r <= 1'b1;
      end else if (out_valid_r && out_ready) begin
        out_valid_r <= 1'b0;
      end
      unique case (state_r)
        S_CLEAR: begin
          if (sts.clear_last) begin
            state_r <= S_IDLE;
          end
        end
        S_IDLE: begin
          if (cmd.load) begin
            state_r <= S_OFS;
          end
        end
        S_OFS:  state_r <= S_MULX;
        S_MULX: state_r <= S_MULY;
        S_MULY: state_r <= S_SETY;
        S_SETY: begin
          state_r <= sts.start_in_map ? S_STEP : S_DONE;
        end
        S_STEP: begin
          state_r <= sts.step_out ? S_DONE : S_CHECK;
        end
        S_CHECK: begin
          priority if (sts.wall || sts.limit) begin
            state_r <= S_DONE;
          end else begin
            state_r <= S_STEP;
          end
        end
        S_DONE: begin
          if (cmd.finish) begin
            state_r <= S_IDLE;
          end
        end
        default: state_r <= S_IDLE;
      endcase
    end
  end

  `GRDDA_ASSERT_NOW(a_finish_free, cmd.finish, !out_valid_r || out_ready, "result overwritten")
  `GRDDA_ASSERT_NOW(a_step_limit, state_r == S_STEP, !sts.limit, "step past limit")
  `GRDDA_ASSERT_NEXT(a_wall_done, state_r == S_CHECK && sts.wall, state_r == S_DONE, "wall missed")
  `GRDDA_ASSERT_NEXT(a_exit_done, state_r == S_STEP && sts.step_out, state_r == S_DONE, "exit missed")

endmodule

// ===== hw/rtl/grid_ray_dda_traversal_core.sv =====
// write item: one per cycle while idle (not during a cast or the clear), no result
// cast item: offset, x multiply, y multiply and y set states, then, if the start cell is in
// the map, per cell step a map read and a wall test, up to a wall, the border or MAX_STEPS steps
// next item taken the cycle after the result register loads; a held result stalls only
// the end of the following cast
// reset: synchronous, active low; all MAP_SIZE * MAP_SIZE cells (4096 by default) then clear
module grid_ray_dda_traversal_core #(
  parameter int unsigned MAP_SIZE  = 64,
  parameter int unsigned MAX_STEPS = 128
) (
  input logic        clk,
  input logic        rst_n,
  grdda_in_if.sink   in_if,
  grdda_out_if.source out_if
);

  grdda_pkg::grdda_cmd_t cmd;
  grdda_pkg::grdda_sts_t sts;
  grdda_pkg::grdda_out_t out_data;
  logic                  in_ready;
  logic                  out_valid;

  grdda_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_if.valid),
    .in_action (in_if.data.action),
    .in_ready  (in_ready),
    .out_ready (out_if.ready),
    .out_valid (out_valid),
    .cmd       (cmd),
    .sts       (sts)
  );

  grdda_dp #(
    .MAP_SIZE  (MAP_SIZE),
    .MAX_STEPS (MAX_STEPS)
  ) u_dp (
    .clk      (clk),
    .rst_n    (rst_n),
    .cmd      (cmd),
    .in_data  (in_if.data),
    .sts      (sts),
    .out_data (out_data)
  );

  assign in_if.ready  = in_ready;
  assign out_if.valid = out_valid;
  assign out_if.data  = out_data;

endmodule

// ===== tb/testbench.sv =====
`timescale 1ns / 1ps

module testbench;

  localparam int MAP_DIM     = 64;
  localparam int STEP_LIMIT  = 128;
  localparam int N_RANDOM    = 1880;
  localparam int DRAIN_WAIT  = 300;
  localparam int CYCLE_LIMIT = 2000000;

  typedef struct {
    grdda_pkg::grdda_in_t  stim;
    bit                    known;
    grdda_pkg::grdda_out_t ray_end;
  } ray_row_t;

  logic clk;
  logic rst_n = 1'b0;
  logic take_ok = 1'b0;
  int tx_idle_pct = 15;
  int rx_idle_pct = 72;
  int err_count = 0;
  int unsigned cycle_count = 0;

  bit wall_bits [MAP_DIM*MAP_DIM];
  grdda_pkg::grdda_out_t hits_due [$];
  ray_row_t plan [$];

  grdda_in_if  in_ch ();
  grdda_out_if out_ch ();

  assign out_ch.ready = take_ok;

  grid_ray_dda_traversal_core DUT (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_if  (in_ch),
    .out_if (out_ch)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("FAIL grid_ray_dda_traversal_core");
      $finish;
    end
  end

  always @(posedge clk) begin
    take_ok <= ($urandom_range(99) >= rx_idle_pct);
  end

  task automatic report(input string msg);
    $display("mismatch: %s", msg);
    err_count++;
  endtask

  task automatic check_field(input string name, input logic [31:0] got,
                             input logic [31:0] want);
    if (got !== want)
      report($sformatf("%s got %0h expected %0h", name, got, want));
  endtask

  function automatic logic [31:0] start_dist(input logic [5:0] cidx,
                                             input logic [21:0] pos,
                                             input logic neg,
                                             input logic [23:0] dlt);
    logic [22:0] bound;
    logic [22:0] off;
    logic [46:0] prod;
    if (dlt == grdda_pkg::DELTA_INF) return '1;
    if (neg) begin
      bound = {1'b0, cidx, 16'h0};
      off = (pos > bound) ? {1'b0, pos} - bound : '0;
    end else begin
      bound = {1'b0, cidx, 16'h0} + 23'h10000;
      off = (bound > pos) ? bound - {1'b0, pos} : '0;
    end
    prod = ({24'd0, off} * {23'd0, dlt}) >> grdda_pkg::FRAC_W;
    if (prod > 47'hFFFF_FFFF) return '1;
    return prod[31:0];
  endfunction

  function automatic logic [31:0] advance_dist(input logic [31:0] d,
                                               input logic [23:0] dlt);
    logic [32:0] sum;
    if (dlt == grdda_pkg::DELTA_INF) return '1;
    sum = {1'b0, d} + {9'd0, dlt};
    return sum[32] ? 32'hFFFF_FFFF : sum[31:0];
  endfunction

  function automatic grdda_pkg::grdda_out_t trace_ray(input grdda_pkg::grdda_in_t it);
    grdda_pkg::grdda_out_t r;
    logic [31:0] sx;
    logic [31:0] sy;
    int x;
    int y;
    int nx;
    int ny;
    logic axis;
    logic stat;
    sx = start_dist(it.cell_x, it.pos_x, it.dir_x_negative, it.delta_x);
    sy = start_dist(it.cell_y, it.pos_y, it.dir_y_negative, it.delta_y);
    x = int'(it.cell_x);
    y = int'(it.cell_y);
    axis = grdda_pkg::AXIS_X;
    stat = grdda_pkg::STAT_MISS;
    for (int n = 0; n < STEP_LIMIT; n++) begin
      nx = x;
      ny = y;
      if (sx < sy) begin
        sx = advance_dist(sx, it.delta_x);
        nx += it.dir_x_negative ? -1 : 1;
        axis = grdda_pkg::AXIS_X;
      end else begin
        sy = advance_dist(sy, it.delta_y);
        ny += it.dir_y_negative ? -1 : 1;
        axis = grdda_pkg::AXIS_Y;
      end
      if (nx < 0 || ny < 0 || nx >= MAP_DIM || ny >= MAP_DIM) break;
      x = nx;
      y = ny;
      if (wall_bits[x*MAP_DIM + y]) begin
        stat = grdda_pkg::STAT_WALL;
        break;
      end
    end
    r.status = stat;
    r.hit_axis = axis;
    r.hit_cell_x = x[5:0];
    r.hit_cell_y = y[5:0];
    r.side_dist_x = sx;
    r.side_dist_y = sy;
    return r;
  endfunction

  function automatic grdda_pkg::grdda_in_t cast_item(
    input logic [5:0] cx, input logic [5:0] cy,
    input logic [21:0] px, input logic [21:0] py,
    input logic nx, input logic ny,
    input logic [23:0] dx, input logic [23:0] dy
  );
    grdda_pkg::grdda_in_t it;
    it = '0;
    it.action = grdda_pkg::ACT_CAST;
    it.cell_x = cx;
    it.cell_y = cy;
    it.pos_x = px;
    it.pos_y = py;
    it.dir_x_negative = nx;
    it.dir_y_negative = ny;
    it.delta_x = dx;
    it.delta_y = dy;
    return it;
  endfunction

  function automatic grdda_pkg::grdda_in_t write_item(input logic [5:0] cx,
                                                      input logic [5:0] cy,
                                                      input logic w);
    grdda_pkg::grdda_in_t it;
    it = '0;
    it.action = grdda_pkg::ACT_WRITE;
    it.cell_x = cx;
    it.cell_y = cy;
    it.wall = w;
    return it;
  endfunction

  function automatic grdda_pkg::grdda_out_t stop_at(
    input logic st, input logic ax,
    input logic [5:0] hx, input logic [5:0] hy,
    input logic [31:0] sx, input logic [31:0] sy
  );
    grdda_pkg::grdda_out_t r;
    r.status = st;
    r.hit_axis = ax;
    r.hit_cell_x = hx;
    r.hit_cell_y = hy;
    r.side_dist_x = sx;
    r.side_dist_y = sy;
    return r;
  endfunction

  task automatic add_row(input grdda_pkg::grdda_in_t it, input bit known,
                         input grdda_pkg::grdda_out_t r);
    ray_row_t row;
    row.stim = it;
    row.known = known;
    row.ray_end = r;
    plan.push_back(row);
  endtask

  function automatic logic [23:0] rand_delta();
    int pick;
    pick = $urandom_range(19);
    if (pick == 0) return grdda_pkg::DELTA_INF;
    if (pick == 1) return '0;
    if (pick == 2) return 24'($urandom);
    return 24'($urandom_range(24'h40000, 1));
  endfunction

  function automatic grdda_pkg::grdda_in_t rand_item();
    grdda_pkg::grdda_in_t it;
    it.action = ($urandom_range(99) < 60) ? grdda_pkg::ACT_CAST : grdda_pkg::ACT_WRITE;
    it.cell_x = 6'($urandom);
    it.cell_y = 6'($urandom);
    it.wall = ($urandom_range(99) < 70);
    it.pos_x = ($urandom_range(9) < 8) ? {it.cell_x, 16'($urandom)} : 22'($urandom);
    it.pos_y = ($urandom_range(9) < 8) ? {it.cell_y, 16'($urandom)} : 22'($urandom);
    it.dir_x_negative = 1'($urandom);
    it.dir_y_negative = 1'($urandom);
    it.delta_x = rand_delta();
    it.delta_y = rand_delta();
    return it;
  endfunction

  task automatic send_item(input grdda_pkg::grdda_in_t it, input bit known,
                           input grdda_pkg::grdda_out_t r);
    while ($urandom_range(99) < tx_idle_pct) begin
      in_ch.valid <= 1'b0;
      @(posedge clk);
    end
    in_ch.valid <= 1'b1;
    in_ch.data <= it;
    do @(negedge clk); while (!in_ch.ready);
    @(posedge clk);
    if (it.action == grdda_pkg::ACT_WRITE)
      wall_bits[it.cell_x*MAP_DIM + it.cell_y] = it.wall;
    else
      hits_due.push_back(known ? r : trace_ray(it));
  endtask

  always @(negedge clk) begin : watch_results
    grdda_pkg::grdda_out_t want;
    if (rst_n && out_ch.valid && out_ch.ready) begin
      if (hits_due.size() == 0) begin
        report($sformatf("result with nothing expected: %0h", out_ch.data));
      end else begin
        want = hits_due.pop_front();
        check_field("status", 32'(out_ch.data.status), 32'(want.status));
        check_field("hit_axis", 32'(out_ch.data.hit_axis), 32'(want.hit_axis));
        check_field("hit_cell_x", 32'(out_ch.data.hit_cell_x), 32'(want.hit_cell_x));
        check_field("hit_cell_y", 32'(out_ch.data.hit_cell_y), 32'(want.hit_cell_y));
        check_field("side_dist_x", out_ch.data.side_dist_x, want.side_dist_x);
        check_field("side_dist_y", out_ch.data.side_dist_y, want.side_dist_y);
      end
    end
  end

  initial begin : stimulus
    grdda_pkg::grdda_out_t none;
    none = '0;
    in_ch.valid <= 1'b0;
    in_ch.data <= '0;
    repeat (11) @(posedge clk);
    rst_n <= 1'b1;

    // empty map: rays run to the border
    add_row(cast_item(0, 0, 0, 0, 0, 0, grdda_pkg::DELTA_INF, grdda_pkg::DELTA_INF), 1,
            stop_at(grdda_pkg::STAT_MISS, grdda_pkg::AXIS_Y, 0, 63, '1, '1));
    add_row(cast_item(5, 0, 0, 0, 0, 1, grdda_pkg::DELTA_INF, grdda_pkg::DELTA_INF), 1,
            stop_at(grdda_pkg::STAT_MISS, grdda_pkg::AXIS_Y, 5, 0, '1, '1));
    add_row(cast_item(10, 20, 0, 0, 0, 0, 0, 0), 1,
            stop_at(grdda_pkg::STAT_MISS, grdda_pkg::AXIS_Y, 10, 63, 0, 0));
    add_row(cast_item(7, 9, 0, 0, 1, 0, 0, grdda_pkg::DELTA_INF), 1,
            stop_at(grdda_pkg::STAT_MISS, grdda_pkg::AXIS_X, 0, 9, 0, '1));
    // wall hits, start cell not tested, cleared wall
    add_row(write_item(3, 0, 1), 0, none);
    add_row(cast_item(0, 0, 0, 0, 0, 0, 0, grdda_pkg::DELTA_INF), 1,
            stop_at(grdda_pkg::STAT_WALL, grdda_pkg::AXIS_X, 3, 0, 0, '1));
    add_row(write_item(3, 5, 1), 0, none);
    add_row(cast_item(3, 2, 0, 0, 0, 0, grdda_pkg::DELTA_INF, grdda_pkg::DELTA_INF), 1,
            stop_at(grdda_pkg::STAT_WALL, grdda_pkg::AXIS_Y, 3, 5, '1, '1));
    add_row(cast_item(3, 5, 0, 0, 0, 0, grdda_pkg::DELTA_INF, grdda_pkg::DELTA_INF), 1,
            stop_at(grdda_pkg::STAT_MISS, grdda_pkg::AXIS_Y, 3, 63, '1, '1));
    add_row(write_item(3, 0, 0), 0, none);
    add_row(cast_item(0, 0, 0, 0, 0, 0, 0, grdda_pkg::DELTA_INF), 1,
            stop_at(grdda_pkg::STAT_MISS, grdda_pkg::AXIS_X, 63, 0, 0, '1));
    add_row(write_item(63, 63, 1), 0, none);
    add_row(cast_item(63, 60, 0, 0, 0, 0, grdda_pkg::DELTA_INF, grdda_pkg::DELTA_INF), 1,
            stop_at(grdda_pkg::STAT_WALL, grdda_pkg::AXIS_Y, 63, 63, '1, '1));
    // field extremes, clamped offsets, ties
    add_row(cast_item(63, 63, 22'h3FFFFF, 22'h3FFFFF, 1, 1, 24'hFFFFFE, 24'hFFFFFE), 0, none);
    add_row(cast_item(0, 0, 22'h3FFFFF, 22'h3FFFFF, 0, 0, 24'hFFFFFE, 24'hFFFFFE), 0, none);
    add_row(cast_item(63, 0, 0, 0, 1, 0, 24'h10000, 24'h20000), 0, none);
    add_row(cast_item(20, 20, 22'h148000, 22'h148000, 0, 0, 24'h10000, 24'h10000), 0, none);
    add_row(cast_item(31, 31, 22'h1FFFFF, 22'h1FFFFF, 1, 1, 24'h1, grdda_pkg::DELTA_INF), 0,
            none);
    add_row(write_item(40, 41, 1), 0, none);
    add_row(cast_item(30, 33, 22'h1E4000, 22'h21C000, 0, 0, 24'h13000, 24'h1A000), 0, none);
    add_row(cast_item(60, 50, 22'h3C0001, 22'h32FFFF, 1, 1, 24'h28000, 24'h9000), 0, none);
    add_row(write_item(0, 0, 0), 0, none);

    foreach (plan[i])
      send_item(plan[i].stim, plan[i].known, plan[i].ray_end);

    for (int i = 0; i < N_RANDOM; i++) begin
      if (i == N_RANDOM / 3) begin
        tx_idle_pct = 72;
        rx_idle_pct = 15;
      end else if (i == 2 * N_RANDOM / 3) begin
        tx_idle_pct = 0;
        rx_idle_pct = 0;
      end
      send_item(rand_item(), 0, none);
    end
    in_ch.valid <= 1'b0;

    while (hits_due.size() != 0) @(posedge clk);
    repeat (DRAIN_WAIT) @(posedge clk);
    if (err_count == 0)
      $display("PASS grid_ray_dda_traversal_core");
    else
      $display("FAIL grid_ray_dda_traversal_core");
    $finish;
  end

endmodule
